@@ design/rar_pkg.sv @@
// Package for the rational arithmetic reduction block.
// Holds the operation codes and the fixed result width; no dependencies.
package rar_pkg;

  localparam int RES_W = 33;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } act_e;

endpackage

@@ design/rar_if.sv @@
// Valid/ready channel interfaces for the operand and result transfers.
// Depends on rar_pkg for the result width.
interface rar_in_if #(parameter int OPERAND_WIDTH = 16);
  logic                            valid;
  logic                            ready;
  logic [1:0]                      action;
  logic signed [OPERAND_WIDTH-1:0] a_num;
  logic signed [OPERAND_WIDTH-1:0] a_den;
  logic signed [OPERAND_WIDTH-1:0] b_num;
  logic signed [OPERAND_WIDTH-1:0] b_den;

  modport source (output valid, action, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, action, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rar_out_if import rar_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] res_num;
  logic signed [RES_W-1:0] res_den;
  logic                    status;

  modport source (output valid, res_num, res_den, status, input ready);
  modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

@@ design/rar_div.sv @@
// Iterative restoring divider for unsigned operands, one quotient bit per cycle.
// Used by rational_arith_reduce_top; no package dependencies.
module rar_div #(
  parameter int W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         busy_o,
  output logic         done_o,
  output logic [W-1:0] quo_o
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  dvs_q;
  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          sub_ok;

  always_comb begin
    shifted = {rem_q, quo_q[W-1]};
    diff    = shifted - {1'b0, dvs_q};
    sub_ok  = ~diff[W];
    rem_d   = sub_ok ? diff[W-1:0] : shifted[W-1:0];
    quo_d   = {quo_q[W-2:0], sub_ok};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q <= '0;
        quo_q <= dividend_i;
        dvs_q <= divisor_i;
        cnt_q <= CW'(W);
      end else if (cnt_q != '0) begin
        rem_q  <= rem_d;
        quo_q  <= quo_d;
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == CW'(1));
      end
    end
  end

  assign busy_o = (cnt_q != '0);
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ design/rational_arith_reduce_top.sv @@
// Top level of the rational arithmetic reduction block.
// Depends on rar_pkg, the channel interfaces in rar_if and the divider rar_div.
//
// Usage: one operand set is taken per transfer on in_i (action, a_num/a_den,
// b_num/b_den); exactly one result follows on out_o (res_num, res_den, status).
// The block handles one item at a time: in_i.ready is high only while idle.
// Work runs on one signed multiplier, a binary GCD unit that takes one
// subtract or shift step a cycle, and one restoring divider used twice.
// Add and subtract pass through S_MUL3, which multiply and divide skip;
// the reduction runs at an internal width R = min(2 * OPERAND_WIDTH + 1, 64).
// A zero denominator or a division by a zero numerator gives status 1 with
// zero outputs in the cycle after the transfer.
// The next input transfer is taken in the cycle after the result transfer at
// the earliest. The result is held in output registers until the receiver
// takes it; a stalled receiver simply holds the block in that state.
// Reset returns the sequencer to idle and drops out_o.valid.
module rational_arith_reduce_top import rar_pkg::*; #(
  parameter int OPERAND_WIDTH = 16
) (
  input logic      clk_i,
  input logic      rst_ni,
  rar_in_if.sink   in_i,
  rar_out_if.source out_o
);

  localparam int OW = OPERAND_WIDTH;
  localparam int PW = 2 * OW;
  localparam int RW = (2 * OW + 1 > 64) ? 64 : 2 * OW + 1;
  localparam int KW = $clog2(RW);
  localparam int EW = (RW + 1 > RES_W) ? RW + 1 : RES_W;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_ABS, S_GCD, S_DIVN, S_DIVD, S_OUT
  } state_e;

  state_e                  state_q;
  act_e                    act_q;
  logic signed [OW-1:0]    an_q, ad_q, bn_q, bd_q;
  logic signed [PW-1:0]    prod_q;
  logic signed [RW-1:0]    num_q, den_q;
  logic [RW-1:0]           nmag_q, dmag_q;
  logic [RW-1:0]           x_q, y_q, g_q;
  logic [KW-1:0]           k_q;
  logic [RES_W-1:0]        rnum_q, rden_q;
  logic                    status_q;
  logic                    div_start_q;

  logic signed [OW-1:0]    mul_a, mul_b;
  logic signed [PW-1:0]    mul_p;
  logic signed [RW-1:0]    prod_ext;
  logic                    in_err;
  logic                    div_busy, div_done;
  logic [RW-1:0]           div_quo;

  function automatic logic [RES_W-1:0] apply_sign(logic [RW-1:0] q, logic neg);
    logic [EW-1:0] ext;
    ext = EW'(q);
    if (neg) begin
      ext = -ext;
    end
    return ext[RES_W-1:0];
  endfunction

  always_comb begin
    mul_a = ad_q;
    mul_b = bd_q;
    unique case (state_q)
      S_MUL0: begin
        mul_a = an_q;
        mul_b = (act_q == ACT_MUL) ? bn_q : bd_q;
      end
      S_MUL1: begin
        case (act_q)
          ACT_ADD, ACT_SUB: begin
            mul_a = bn_q;
            mul_b = ad_q;
          end
          ACT_MUL: begin
            mul_a = ad_q;
            mul_b = bd_q;
          end
          default: begin
            mul_a = ad_q;
            mul_b = bn_q;
          end
        endcase
      end
      default: begin
        mul_a = ad_q;
        mul_b = bd_q;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign prod_ext = RW'(prod_q);
  assign in_err   = (in_i.a_den == '0) || (in_i.b_den == '0) ||
                    ((act_e'(in_i.action) == ACT_DIV) && (in_i.b_num == '0));

  rar_div #(.W(RW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i ((state_q == S_DIVN) ? nmag_q : dmag_q),
    .divisor_i  (g_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_q       <= ACT_ADD;
      an_q        <= '0;
      ad_q        <= '0;
      bn_q        <= '0;
      bd_q        <= '0;
      prod_q      <= '0;
      num_q       <= '0;
      den_q       <= '0;
      nmag_q      <= '0;
      dmag_q      <= '0;
      x_q         <= '0;
      y_q         <= '0;
      g_q         <= '0;
      k_q         <= '0;
      rnum_q      <= '0;
      rden_q      <= '0;
      status_q    <= 1'b0;
      div_start_q <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            act_q <= act_e'(in_i.action);
            an_q  <= in_i.a_num;
            ad_q  <= in_i.a_den;
            bn_q  <= in_i.b_num;
            bd_q  <= in_i.b_den;
            if (in_err) begin
              rnum_q   <= '0;
              rden_q   <= '0;
              status_q <= 1'b1;
              state_q  <= S_OUT;
            end else begin
              status_q <= 1'b0;
              state_q  <= S_MUL0;
            end
          end
        end
        S_MUL0: begin
          prod_q  <= mul_p;
          state_q <= S_MUL1;
        end
        S_MUL1: begin
          num_q   <= prod_ext;
          prod_q  <= mul_p;
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          case (act_q)
            ACT_ADD: begin
              num_q   <= num_q + prod_ext;
              prod_q  <= mul_p;
              state_q <= S_MUL3;
            end
            ACT_SUB: begin
              num_q   <= num_q - prod_ext;
              prod_q  <= mul_p;
              state_q <= S_MUL3;
            end
            default: begin
              den_q   <= prod_ext;
              state_q <= S_ABS;
            end
          endcase
        end
        S_MUL3: begin
          den_q   <= prod_ext;
          state_q <= S_ABS;
        end
        S_ABS: begin
          nmag_q  <= num_q[RW-1] ? RW'(-num_q) : RW'(num_q);
          dmag_q  <= den_q[RW-1] ? RW'(-den_q) : RW'(den_q);
          x_q     <= num_q[RW-1] ? RW'(-num_q) : RW'(num_q);
          y_q     <= den_q[RW-1] ? RW'(-den_q) : RW'(den_q);
          k_q     <= '0;
          state_q <= S_GCD;
        end
        S_GCD: begin
          if (x_q == '0) begin
            g_q         <= y_q << k_q;
            div_start_q <= 1'b1;
            state_q     <= S_DIVN;
          end else if (y_q == '0) begin
            g_q         <= x_q << k_q;
            div_start_q <= 1'b1;
            state_q     <= S_DIVN;
          end else if (!x_q[0] && !y_q[0]) begin
            x_q <= x_q >> 1;
            y_q <= y_q >> 1;
            k_q <= k_q + 1'b1;
          end else if (!x_q[0]) begin
            x_q <= x_q >> 1;
          end else if (!y_q[0]) begin
            y_q <= y_q >> 1;
          end else if (x_q >= y_q) begin
            x_q <= x_q - y_q;
          end else begin
            y_q <= y_q - x_q;
          end
        end
        S_DIVN: begin
          if (div_done) begin
            rnum_q      <= apply_sign(div_quo, num_q[RW-1]);
            div_start_q <= 1'b1;
            state_q     <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (div_done) begin
            rden_q  <= apply_sign(div_quo, den_q[RW-1]);
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_o.ready) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = (state_q == S_OUT);
  assign out_o.res_num = rnum_q;
  assign out_o.res_den = rden_q;
  assign out_o.status  = status_q;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("Input and output sides were open at the same time.");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status) |-> (out_o.res_num == '0 && out_o.res_den == '0))
    else $error("An error result carried nonzero values.");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start_q |-> !div_busy)
    else $error("The divider was started while busy.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("A new transfer was offered right after an accepted one.");

  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVN && div_start_q) |-> (g_q != '0))
    else $error("The divisor for reduction was zero.");

endmodule
